@@ src/rdg_pkg.sv @@
// Shared constants, types and slot arithmetic for the ridge detector.
// No dependencies; imported by every module of the block.
package rdg_pkg;

  localparam int MAX_RADIUS  = 8;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_WIDTH   = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int NSLOTS      = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = NSLOTS * MAX_HEIGHT;

  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SLOT_W = $clog2(NSLOTS);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = SLOT_W + ROW_W;

  // Scan position of the incoming beat; slot is col modulo NSLOTS.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
  } pos_t;

  typedef struct packed {
    logic                          we;
    logic [ADDR_W-1:0]             waddr;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic [ADDR_W-1:0]             raddr_a;
    logic [ADDR_W-1:0]             raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic             flag;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } result_t;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [RAD_W-1:0]  k);
    logic [SLOT_W:0] sum;
    sum = (SLOT_W + 1)'(s) + (SLOT_W + 1)'(k);
    if (sum >= (SLOT_W + 1)'(NSLOTS)) sum = sum - (SLOT_W + 1)'(NSLOTS);
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                 input logic [RAD_W-1:0]  k);
    logic [SLOT_W:0] diff;
    diff = (SLOT_W + 1)'(s) + (SLOT_W + 1)'(NSLOTS) - (SLOT_W + 1)'(k);
    if (diff >= (SLOT_W + 1)'(NSLOTS)) diff = diff - (SLOT_W + 1)'(NSLOTS);
    return diff[SLOT_W-1:0];
  endfunction

endpackage

@@ src/axis_ridge_detector_unit.sv @@
// Top level of the axis ridge detector: register port, scan counters,
// column store and judge sequencer. Depends on rdg_pkg, rdg_store, rdg_judge.
//
// Samples stream in column order (row fastest), one per beat. Each beat is
// written into a circular store of 2*MAX_RADIUS+1 columns; once the scan is
// at least R columns and R rows in, the beat yields one result for the pixel
// R columns and R rows behind it. That pixel is flagged when, along the row
// or the column axis, it is strictly above every neighbor at a larger index
// and not below every neighbor at a smaller index, out to distance R.
// Pixels within R of the left or top edge come out with flag 0; pixels within
// R of the right or bottom edge produce no result. One beat is handled at a
// time. A beat whose pixel is judged goes through the accept, one read of
// the center, the neighbor-pair reads out to distance R (the store has two
// read ports, so one pair per cycle, row axis and column axis alternating),
// the last compare and the load of the result register, which waits while
// that register is full. The default radius is 2. An edge-result beat goes
// from the accept to the result load, a no-result beat ends at the accept. A
// finished result waits in its own register, so the next beat is taken while
// it is still pending. Radius above MAX_RADIUS is clamped, height 0 and width
// 0 act as 1. Registers (APB, write on access phase): 0x0 radius, 0x4
// frame_height, 0x8 frame_width; change them only while the block is idle.
// The store needs no clearing after reset.
module axis_ridge_detector_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   sample_valid_i,
  output logic                                   sample_ready_o,
  input  logic signed [rdg_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   ridge_flag_o,
  output logic [rdg_pkg::COL_W-1:0]              centre_col_o,
  output logic [rdg_pkg::ROW_W-1:0]              centre_row_o
);
  import rdg_pkg::*;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  // Raw register contents, at the widths of the register map
  logic [3:0]  radius_q;
  logic [10:0] height_q;
  logic [12:0] width_q;

  logic [RAD_W-1:0] radius_eff;
  logic [HGT_W-1:0] height_eff;
  logic [WID_W-1:0] width_eff;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic       cfg_write;
  logic [1:0] cfg_index;
  logic       accept;

  pos_t              pos;
  mem_req_t          mem_req;
  logic signed [SAMPLE_BITS-1:0] rdata_a;
  logic signed [SAMPLE_BITS-1:0] rdata_b;
  result_t           result;

  // ---------------------------------------------------------------- APB
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd2;
      height_q <= 11'd1024;
      width_q  <= 13'd1024;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS: radius_q <= pwdata[3:0];
        REG_HEIGHT: height_q <= pwdata[10:0];
        REG_WIDTH:  width_q  <= pwdata[12:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_RADIUS: prdata = 32'(radius_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_WIDTH:  prdata = 32'(width_q);
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------- effective geometry
  always_comb begin
    if (int'(radius_q) > MAX_RADIUS) radius_eff = RAD_W'(MAX_RADIUS);
    else                             radius_eff = RAD_W'(radius_q);

    if (height_q == '0)                    height_eff = HGT_W'(1);
    else if (int'(height_q) > MAX_HEIGHT)  height_eff = HGT_W'(MAX_HEIGHT);
    else                                   height_eff = HGT_W'(height_q);

    if (width_q == '0)                     width_eff = WID_W'(1);
    else if (int'(width_q) > MAX_WIDTH)    width_eff = WID_W'(MAX_WIDTH);
    else                                   width_eff = WID_W'(width_q);
  end

  // ------------------------------------------------------ scan counters
  // slot tracks col modulo the store's column count
  assign accept = sample_valid_i & sample_ready_o;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    if (accept) begin
      if ((HGT_W'(row_q) + HGT_W'(1)) >= height_eff) begin
        row_d = '0;
        if ((WID_W'(col_q) + WID_W'(1)) >= width_eff) begin
          col_d  = '0;
          slot_d = '0;
        end else begin
          col_d  = col_q + COL_W'(1);
          slot_d = slot_add(slot_q, RAD_W'(1));
        end
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

  assign pos.col  = col_q;
  assign pos.row  = row_q;
  assign pos.slot = slot_q;

  // --------------------------------------------------------- datapath
  rdg_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  rdg_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .pos_i          (pos),
    .radius_i       (radius_eff),
    .mem_req_o      (mem_req),
    .rdata_a_i      (rdata_a),
    .rdata_b_i      (rdata_b),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result)
  );

  assign ridge_flag_o = result.flag;
  assign centre_col_o = result.col;
  assign centre_row_o = result.row;

endmodule

@@ src/rdg_store.sv @@
// Column store: NSLOTS columns of MAX_HEIGHT samples, one write and two
// registered read ports. Depends on rdg_pkg.
module rdg_store (
  input  logic                                   clk_i,
  input  rdg_pkg::mem_req_t                      req_i,
  output logic signed [rdg_pkg::SAMPLE_BITS-1:0] rdata_a_o,
  output logic signed [rdg_pkg::SAMPLE_BITS-1:0] rdata_b_o
);
  import rdg_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_a_q;
  logic signed [SAMPLE_BITS-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem_q[req_i.raddr_a];
    rd_b_q <= mem_q[req_i.raddr_b];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

@@ src/rdg_judge.sv @@
// Per-beat sequencer: writes the sample, walks the neighbor pairs through
// the store's two read ports, compares, and holds the result register.
// Depends on rdg_pkg.
module rdg_judge (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   sample_valid_i,
  output logic                                   sample_ready_o,
  input  logic signed [rdg_pkg::SAMPLE_BITS-1:0] sample_i,
  input  rdg_pkg::pos_t                          pos_i,
  input  logic [rdg_pkg::RAD_W-1:0]              radius_i,
  output rdg_pkg::mem_req_t                      mem_req_o,
  input  logic signed [rdg_pkg::SAMPLE_BITS-1:0] rdata_a_i,
  input  logic signed [rdg_pkg::SAMPLE_BITS-1:0] rdata_b_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output rdg_pkg::result_t                       result_o
);
  import rdg_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [1:0] KIND_CTR = 2'd0;
  localparam logic [1:0] KIND_X   = 2'd1;
  localparam logic [1:0] KIND_Y   = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [RAD_W-1:0]              d_q, d_d;
  logic                          axis_q, axis_d;
  logic [COL_W-1:0]              cc_q, cc_d;
  logic [ROW_W-1:0]              cr_q, cr_d;
  logic [SLOT_W-1:0]             slot_cc_q, slot_cc_d;
  logic                          judge_q, judge_d;
  logic                          xmax_q, xmax_d;
  logic                          ymax_q, ymax_d;
  logic signed [SAMPLE_BITS-1:0] centre_q, centre_d;
  logic                          rd_valid_q, rd_valid_d;
  logic [1:0]                    rd_kind_q, rd_kind_d;
  logic                          out_valid_q, out_valid_d;
  result_t                       result_q, result_d;

  logic             accept;
  logic [COL_W-1:0] rad_col;
  logic [ROW_W-1:0] rad_row;
  logic [ROW_W-1:0] d_row;
  logic             pair_ok_a;

  assign sample_ready_o = (state_q == ST_IDLE);
  assign accept         = sample_valid_i & sample_ready_o;
  assign rad_col        = COL_W'(radius_i);
  assign rad_row        = ROW_W'(radius_i);
  assign d_row          = ROW_W'(d_q);

  // Store write and read addressing
  always_comb begin
    mem_req_o.we      = accept;
    mem_req_o.waddr   = {pos_i.slot, pos_i.row};
    mem_req_o.wdata   = sample_i;
    mem_req_o.raddr_a = {slot_cc_q, cr_q};
    mem_req_o.raddr_b = {slot_cc_q, cr_q};
    if (d_q != '0) begin
      if (!axis_q) begin
        mem_req_o.raddr_a = {slot_add(slot_cc_q, d_q), cr_q};
        mem_req_o.raddr_b = {slot_sub(slot_cc_q, d_q), cr_q};
      end else begin
        mem_req_o.raddr_a = {slot_cc_q, ROW_W'(cr_q + d_row)};
        mem_req_o.raddr_b = {slot_cc_q, ROW_W'(cr_q - d_row)};
      end
    end
  end

  // Larger-index neighbor strictly below, smaller-index neighbor not above
  assign pair_ok_a = (centre_q > rdata_a_i) && (centre_q >= rdata_b_i);

  always_comb begin
    state_d     = state_q;
    d_d         = d_q;
    axis_d      = axis_q;
    cc_d        = cc_q;
    cr_d        = cr_q;
    slot_cc_d   = slot_cc_q;
    judge_d     = judge_q;
    xmax_d      = xmax_q;
    ymax_d      = ymax_q;
    centre_d    = centre_q;
    rd_valid_d  = 1'b0;
    rd_kind_d   = rd_kind_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;

    if (rd_valid_q) begin
      unique case (rd_kind_q)
        KIND_CTR: centre_d = rdata_a_i;
        KIND_X:   if (!pair_ok_a) xmax_d = 1'b0;
        KIND_Y:   if (!pair_ok_a) ymax_d = 1'b0;
        default:  ;
      endcase
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cc_d      = pos_i.col - rad_col;
          cr_d      = pos_i.row - rad_row;
          slot_cc_d = slot_sub(pos_i.slot, radius_i);
          judge_d   = (radius_i != '0) && (cc_d >= rad_col) && (cr_d >= rad_row);
          xmax_d    = 1'b1;
          ymax_d    = 1'b1;
          d_d       = '0;
          axis_d    = 1'b0;
          if ((pos_i.col >= rad_col) && (pos_i.row >= rad_row)) begin
            state_d = judge_d ? ST_READ : ST_FINISH;
          end
        end
      end
      ST_READ: begin
        rd_valid_d = 1'b1;
        rd_kind_d  = (d_q == '0) ? KIND_CTR : (axis_q ? KIND_Y : KIND_X);
        if (d_q == '0) begin
          d_d    = RAD_W'(1);
          axis_d = 1'b0;
        end else if (!axis_q) begin
          axis_d = 1'b1;
        end else if (d_q == radius_i) begin
          state_d = ST_FINISH;
        end else begin
          d_d    = d_q + RAD_W'(1);
          axis_d = 1'b0;
        end
      end
      ST_FINISH: begin
        // wait for the last compare, then for a free result register
        if (!rd_valid_q && (!out_valid_q || out_ready_i)) begin
          out_valid_d   = 1'b1;
          result_d.flag = judge_q & (xmax_q | ymax_q);
          result_d.col  = cc_q;
          result_d.row  = cr_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    axis_q    <= axis_d;
    cc_q      <= cc_d;
    cr_q      <= cr_d;
    slot_cc_q <= slot_cc_d;
    judge_q   <= judge_d;
    xmax_q    <= xmax_d;
    ymax_q    <= ymax_d;
    centre_q  <= centre_d;
    rd_kind_q <= rd_kind_d;
    result_q  <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
